// ----- src/e2rm_pkg.sv -----
// ----------------------------------------------------------------------------
// ZYX Euler-angle rotation block: shared types and constants
// Request/result payloads, angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package e2rm_pkg;

  typedef struct packed {
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } e2rm_in_t;

  typedef struct packed {
    logic signed [15:0] r00;
    logic signed [15:0] r10;
    logic signed [15:0] r20;
    logic signed [15:0] r01;
    logic signed [15:0] r11;
    logic signed [15:0] r21;
    logic signed [15:0] r02;
    logic signed [15:0] r12;
    logic signed [15:0] r22;
  } e2rm_out_t;

  // Q4.30 working values; 34 bits covers the +-4 rad angle residue and sums
  localparam int WW = 34;
  localparam int WORK_FRAC = 30;
  localparam int MAX_STEPS = 24;

  localparam logic signed [WW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [WW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [WW-1:0] GAIN_Q30    = 34'sd652032874;

  function automatic logic signed [WW-1:0] atan_q30(input int i);
    logic signed [WW-1:0] t;
    t = '0;
    case (i)
      0: t = 34'sd843314857;   1: t = 34'sd497837829;
      2: t = 34'sd263043837;   3: t = 34'sd133525159;
      4: t = 34'sd67021687;    5: t = 34'sd33543516;
      6: t = 34'sd16775851;    7: t = 34'sd8388437;
      8: t = 34'sd4194283;     9: t = 34'sd2097149;
      10: t = 34'sd1048576;    11: t = 34'sd524288;
      12: t = 34'sd262144;     13: t = 34'sd131072;
      14: t = 34'sd65536;      15: t = 34'sd32768;
      16: t = 34'sd16384;      17: t = 34'sd8192;
      18: t = 34'sd4096;       19: t = 34'sd2048;
      20: t = 34'sd1024;       21: t = 34'sd512;
      22: t = 34'sd256;        23: t = 34'sd128;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ----- src/e2rm_cordic.sv -----
// ----------------------------------------------------------------------------
// Pipelined CORDIC cosine/sine
// Negates and range-reduces one Q3.13 angle into a register, then runs one rotation step per
// register stage. It accepts one angle per cycle.
// ----------------------------------------------------------------------------
module e2rm_cordic #(
  parameter int STEPS = 16
) (
  input  logic                             clk,
  input  logic signed [15:0]               angle,
  output logic signed [e2rm_pkg::WW-1:0]   cos_o,
  output logic signed [e2rm_pkg::WW-1:0]   sin_o
);
  import e2rm_pkg::*;

  logic signed [WW-1:0] x_r [0:STEPS];
  logic signed [WW-1:0] y_r [0:STEPS];
  logic signed [WW-1:0] z_r [0:STEPS];
  logic                 flip_r [0:STEPS];

  logic signed [WW-1:0] z0;
  always_comb begin
    z0 = -(WW'(angle) <<< 17);
  end

  always_ff @(posedge clk) begin
    x_r[0] <= GAIN_Q30;
    y_r[0] <= '0;
    if (z0 > HALF_PI_Q30) begin
      z_r[0] <= z0 - PI_Q30;
      flip_r[0] <= 1'b1;
    end else if (z0 < -HALF_PI_Q30) begin
      z_r[0] <= z0 + PI_Q30;
      flip_r[0] <= 1'b1;
    end else begin
      z_r[0] <= z0;
      flip_r[0] <= 1'b0;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      flip_r[i+1] <= flip_r[i];
      if (!z_r[i][WW-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_q30(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_q30(i);
      end
    end
  end

  assign cos_o = flip_r[STEPS] ? -x_r[STEPS] : x_r[STEPS];
  assign sin_o = flip_r[STEPS] ? -y_r[STEPS] : y_r[STEPS];

endmodule

// ----- src/euler_to_rotation_matrix.sv -----
// ----------------------------------------------------------------------------
// ZYX Euler-angle to 3x3 rotation matrix
// Pipeline: CORDIC stages,
// a sign-fix stage, two product stages, one rounding stage.
// Throughput: one request per cycle; busy is tied low, out_valid pulses once.
// Reset: rst_n (synchronous) clears only the valid pipeline; no state is kept.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix #(
  parameter int CORDIC_STEPS  = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  e2rm_pkg::e2rm_in_t   in_data,
  output logic                 out_valid,
  output e2rm_pkg::e2rm_out_t  out_data
);
  import e2rm_pkg::*;

  localparam int NST = (CORDIC_STEPS > MAX_STEPS) ? MAX_STEPS : CORDIC_STEPS;
  localparam int LAT = NST + 5;
  localparam int SH  = WORK_FRAC - OUT_FRAC_BITS;
  localparam logic signed [WW-1:0] LIM = WW'(1) <<< OUT_FRAC_BITS;

  logic take;
  assign busy = 1'b0;
  assign take = start & ~busy;

  logic [LAT-1:0] vld_r;
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else        vld_r <= {vld_r[LAT-2:0], take};
  end

  logic signed [WW-1:0] cx, sx, cy, sy, cz, sz;
  e2rm_cordic #(.STEPS(NST)) u_cx (.clk(clk), .angle(in_data.angle_x), .cos_o(cx), .sin_o(sx));
  e2rm_cordic #(.STEPS(NST)) u_cy (.clk(clk), .angle(in_data.angle_y), .cos_o(cy), .sin_o(sy));
  e2rm_cordic #(.STEPS(NST)) u_cz (.clk(clk), .angle(in_data.angle_z), .cos_o(cz), .sin_o(sz));

  // register the sign-fixed trig values
  logic signed [WW-1:0] cx_r, sx_r, cy_r, sy_r, cz_r, sz_r;
  always_ff @(posedge clk) begin
    cx_r <= cx; sx_r <= sx; cy_r <= cy; sy_r <= sy; cz_r <= cz; sz_r <= sz;
  end

  function automatic logic signed [WW-1:0] qmul(input logic signed [WW-1:0] a,
                                                input logic signed [WW-1:0] b);
    logic signed [2*WW-1:0] p;
    p = (2*WW)'(a) * (2*WW)'(b) + ((2*WW)'(1) <<< (WORK_FRAC - 1));
    return WW'(p >>> WORK_FRAC);
  endfunction

  // first product stage
  logic signed [WW-1:0] czsy_r, szsy_r, szcx_r, szsx_r, czcx_r, czsx_r;
  logic signed [WW-1:0] p00_r, p01_r, p12_r, p22_r, nsy_r, sx2_r, cx2_r;
  always_ff @(posedge clk) begin
    czsy_r <= qmul(cz_r, sy_r);
    szsy_r <= qmul(sz_r, sy_r);
    szcx_r <= qmul(sz_r, cx_r);
    szsx_r <= qmul(sz_r, sx_r);
    czcx_r <= qmul(cz_r, cx_r);
    czsx_r <= qmul(cz_r, sx_r);
    p00_r  <= qmul(cz_r, cy_r);
    p01_r  <= qmul(sz_r, cy_r);
    p12_r  <= qmul(cy_r, sx_r);
    p22_r  <= qmul(cy_r, cx_r);
    nsy_r  <= -sy_r;
    sx2_r  <= sx_r;
    cx2_r  <= cx_r;
  end

  // second product stage and sums
  logic signed [WW-1:0] s10_r, s20_r, s11_r, s21_r;
  logic signed [WW-1:0] q00_r, q01_r, q02_r, q12_r, q22_r;
  always_ff @(posedge clk) begin
    s10_r <= qmul(czsy_r, sx2_r) - szcx_r;
    s20_r <= qmul(czsy_r, cx2_r) + szsx_r;
    s11_r <= qmul(szsy_r, sx2_r) + czcx_r;
    s21_r <= qmul(szsy_r, cx2_r) - czsx_r;
    q00_r <= p00_r; q01_r <= p01_r; q02_r <= nsy_r; q12_r <= p12_r; q22_r <= p22_r;
  end

  function automatic logic [15:0] to_out(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] r;
    r = (v + (WW'(1) <<< (SH - 1))) >>> SH;
    if (r > LIM)  r = LIM;
    if (r < -LIM) r = -LIM;
    return r[15:0];
  endfunction

  e2rm_out_t res_r;
  always_ff @(posedge clk) begin
    res_r.r00 <= to_out(q00_r);
    res_r.r10 <= to_out(s10_r);
    res_r.r20 <= to_out(s20_r);
    res_r.r01 <= to_out(q01_r);
    res_r.r11 <= to_out(s11_r);
    res_r.r21 <= to_out(s21_r);
    res_r.r02 <= to_out(q02_r);
    res_r.r12 <= to_out(q12_r);
    res_r.r22 <= to_out(q22_r);
  end

  assign out_valid = vld_r[LAT-1];
  assign out_data  = res_r;

  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(take, LAT))
    else $error("result without matching request");
  a_never_busy: assert property (@(posedge clk) !busy)
    else $error("busy asserted");
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_data.r02) <= $signed(16'(LIM)) || OUT_FRAC_BITS > 14))
    else $error("r02 exceeds saturation limit");

endmodule

// ----- tb/sv/euler_to_rotation_matrix_checker.sv -----
// ----------------------------------------------------------------------------
// Rotation matrix checker
// Watches requests and results of the Euler-angle block, predicts each matrix
// with a bit-exact CORDIC and product model, and counts mismatched entries.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_checker #(
  parameter int CORDIC_STEPS  = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  e2rm_pkg::e2rm_in_t   in_data,
  input  logic                 out_valid,
  input  e2rm_pkg::e2rm_out_t  out_data,
  output int                   fail_count,
  output int                   pending,
  output int                   matrices_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import e2rm_pkg::*;

  localparam longint PI_W   = 64'sd3373259426;
  localparam longint HALF_W = 64'sd1686629713;
  localparam longint GAIN_W = 64'sd652032874;

  e2rm_out_t matrix_q[$];

  function automatic longint atan_entry(input int i);
    longint tab[24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288,
      262144, 131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
      256, 128};
    return tab[i];
  endfunction

  function automatic void angle_cos_sin(input logic signed [15:0] ang,
                                        output longint c, output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    int steps;
    z = -longint'(ang) * 131072;
    x = GAIN_W;
    y = 0;
    flip = 0;
    steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
    if (z > HALF_W) begin
      z -= PI_W;
      flip = 1;
    end else if (z < -HALF_W) begin
      z += PI_W;
      flip = 1;
    end
    for (int i = 0; i < steps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return (a * b + (64'sd1 << 29)) >>> 30;
  endfunction

  function automatic logic [15:0] to_q14(input longint v);
    int sh;
    longint lim, r;
    sh = 30 - OUT_FRAC_BITS;
    lim = 64'sd1 << OUT_FRAC_BITS;
    r = (v + (64'sd1 << (sh - 1))) >>> sh;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

  function automatic e2rm_out_t predict_matrix(input e2rm_in_t a);
    longint cx, sx, cy, sy, cz, sz;
    e2rm_out_t m;
    angle_cos_sin(a.angle_x, cx, sx);
    angle_cos_sin(a.angle_y, cy, sy);
    angle_cos_sin(a.angle_z, cz, sz);
    m.r00 = to_q14(qmul(cz, cy));
    m.r10 = to_q14(qmul(qmul(cz, sy), sx) - qmul(sz, cx));
    m.r20 = to_q14(qmul(qmul(cz, sy), cx) + qmul(sz, sx));
    m.r01 = to_q14(qmul(sz, cy));
    m.r11 = to_q14(qmul(qmul(sz, sy), sx) + qmul(cz, cx));
    m.r21 = to_q14(qmul(qmul(sz, sy), cx) - qmul(cz, sx));
    m.r02 = to_q14(-sy);
    m.r12 = to_q14(qmul(cy, sx));
    m.r22 = to_q14(qmul(cy, cx));
    return m;
  endfunction

  task automatic check_entry(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count++;
    end
  endtask

  initial begin
    fail_count = 0;
    matrices_seen = 0;
  end

  assign pending = matrix_q.size();

  always @(posedge clk) begin
    e2rm_out_t want;
    if (rst_n && start && !busy) matrix_q.push_back(predict_matrix(in_data));
    if (rst_n && out_valid) begin
      matrices_seen++;
      if (matrix_q.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        want = matrix_q.pop_front();
        check_entry("r00", want.r00, out_data.r00);
        check_entry("r10", want.r10, out_data.r10);
        check_entry("r20", want.r20, out_data.r20);
        check_entry("r01", want.r01, out_data.r01);
        check_entry("r11", want.r11, out_data.r11);
        check_entry("r21", want.r21, out_data.r21);
        check_entry("r02", want.r02, out_data.r02);
        check_entry("r12", want.r12, out_data.r12);
        check_entry("r22", want.r22, out_data.r22);
      end
    end
  end

endmodule

// ----- tb/sv/euler_to_rotation_matrix_test.sv -----
// ----------------------------------------------------------------------------
// Euler-angle rotation block testbench
// Drives directed and random angle triples, with random gaps or back-to-back
// bursts; the checker predicts every matrix and this top reports the verdict.
// ----------------------------------------------------------------------------
module euler_to_rotation_matrix_test;
  timeunit 1ns;
  timeprecision 1ps;
  import e2rm_pkg::*;

  localparam int LATENCY     = 16 + 5;
  localparam int NUM_RANDOM  = 750;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  e2rm_in_t in_data = '0;
  logic out_valid;
  e2rm_out_t out_data;
  int fail_count, pending, matrices_seen;
  int cycles = 0;
  int sent = 0;

  always #2 clk = ~clk;

  euler_to_rotation_matrix u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  euler_to_rotation_matrix_checker u_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .fail_count(fail_count),
    .pending(pending), .matrices_seen(matrices_seen)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 2 * 25736) - 25736);
      2: return 16'($urandom_range(0, 400) + 12868 - 200);
      default: return 16'($urandom_range(0, 2 * 25736) - 25736);
    endcase
  endfunction

  // drop start for a random gap unless no_gap is set, then hold it until the request is taken
  task automatic send_request(input logic [15:0] ax, input logic [15:0] ay,
                              input logic [15:0] az, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      start <= 0;
      repeat (gap) @(posedge clk);
    end
    start <= 1;
    in_data <= '{angle_x: ax, angle_y: ay, angle_z: az};
    do @(posedge clk); while (busy);
    sent++;
  endtask

  initial begin
    logic [15:0] edges[11];
    bit burst;
    edges = '{16'sd0, 16'sd25736, -16'sd25736, 16'sd12868, -16'sd12868,
              16'sd12869, -16'sd12869, 16'h7fff, 16'h8000, 16'sd1, -16'sd1};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    for (int i = 0; i < 11; i++) send_request(edges[i], edges[(i + 3) % 11],
                                              edges[(i + 7) % 11], 0);
    send_request(16'h7fff, 16'h7fff, 16'h7fff, 1);
    send_request(16'h8000, 16'h8000, 16'h8000, 1);
    send_request(16'h5555, 16'haaaa, 16'h5555, 0);
    send_request(16'haaaa, 16'h5555, 16'haaaa, 0);
    start <= 0;
    // pause until the pipeline drains
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      burst = (i / 50) % 3 == 1;
      send_request(rand_angle(), rand_angle(), rand_angle(), burst);
    end
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d angle triples (edges, wraps, full 16-bit range)", sent);
    $display("Checked %0d matrices with random gaps and back-to-back bursts",
             matrices_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/e2rm_pkg.sv
src/e2rm_cordic.sv
src/euler_to_rotation_matrix.sv
tb/sv/euler_to_rotation_matrix_checker.sv
tb/sv/euler_to_rotation_matrix_test.sv
